>>> hw/rtl/qshdc_pkg.sv
// ----------------------------------------------------------------------------
// qshdc_pkg
// shared types, constants and helpers for the discipline checker
// ----------------------------------------------------------------------------
package qshdc_pkg;

   localparam int DEPTH      = 1024;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = ADDR_BITS + 1;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [2:0] VERDICT_NONE  = 3'd0;
   localparam logic [2:0] VERDICT_MULTI = 3'd1;
   localparam logic [2:0] VERDICT_QUEUE = 3'd2;
   localparam logic [2:0] VERDICT_STACK = 3'd3;
   localparam logic [2:0] VERDICT_PRIO  = 3'd4;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [CNT_BITS-1:0]   count_type;

   typedef struct packed {
      logic     clear;
      logic     en;
      addr_type idx;
   } max_ctl_type;

   function automatic logic [2:0] verdict_of(input logic [2:0] mask);
      logic [2:0] v;
      unique case (mask)
         3'b000:  v = VERDICT_NONE;
         3'b001:  v = VERDICT_QUEUE;
         3'b010:  v = VERDICT_STACK;
         3'b100:  v = VERDICT_PRIO;
         default: v = VERDICT_MULTI;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/qshdc_ram.sv
// ----------------------------------------------------------------------------
// qshdc_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module qshdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/qshdc_max_unit.sv
// ----------------------------------------------------------------------------
// qshdc_max_unit
// magnitude compare unit, keeps the running maximum and its index
// ----------------------------------------------------------------------------
module qshdc_max_unit (
   input  logic                   clock,
   input  qshdc_pkg::max_ctl_type ctl,
   input  qshdc_pkg::value_type   data,
   output qshdc_pkg::value_type   best_val,
   output qshdc_pkg::addr_type    best_idx
);

   logic                 valid_ff, valid_in;
   qshdc_pkg::value_type val_ff, val_in;
   qshdc_pkg::addr_type  idx_ff, idx_in;

   always_comb begin
      valid_in = valid_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.en && (!valid_ff || data > val_ff)) begin
         valid_in = 1'b1;
         val_in   = data;
         idx_in   = ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      val_ff   <= val_in;
      idx_ff   <= idx_in;
   end

   assign best_val = val_ff;
   assign best_idx = idx_ff;

endmodule

>>> hw/rtl/queue_stack_heap_discipline_checker.sv
// ----------------------------------------------------------------------------
// queue_stack_heap_discipline_checker
// tracks queue, stack and priority queue models and reports which fit
// ----------------------------------------------------------------------------
//   channel | ports                          | handshake
//   request | req_opcode, req_value          | start & !busy
//   result  | rsp_candidate_mask, rsp_verdict, rsp_overflow | rsp_valid, one cycle
//
//   insert, restart, unused opcode: straight from idle to the result state
//   remove: idle, model check, then result; or while the priority model lives
//     with a nonempty store, a scan over every stored word, a heap check and, on
//     a match, a heap write before the result; the max scan over the priority
//     store is linear, through one compare unit and one read port
//   one word at a time; busy stays high until the result cycle has ended
//   synchronous reset, no clearing pass; the receiver cannot stall
// ----------------------------------------------------------------------------
module queue_stack_heap_discipline_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_opcode,
   input  logic [31:0]              req_value,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_candidate_mask,
   output logic [2:0]               rsp_verdict,
   output logic                     rsp_overflow
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_QCHK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_HCHK = 3'd3;
   localparam logic [2:0] S_HWR  = 3'd4;
   localparam logic [2:0] S_RSP  = 3'd5;

   localparam int DEPTH = qshdc_pkg::DEPTH;
   localparam int AB    = qshdc_pkg::ADDR_BITS;
   localparam int CB    = qshdc_pkg::CNT_BITS;

   logic [2:0]            state_ff, state_in;
   qshdc_pkg::value_type  val_ff, val_in;
   qshdc_pkg::addr_type   fhead_ff, fhead_in;
   qshdc_pkg::count_type  fcount_ff, fcount_in;
   qshdc_pkg::count_type  lcount_ff, lcount_in;
   qshdc_pkg::count_type  hcount_ff, hcount_in;
   qshdc_pkg::count_type  scan_ff, scan_in;
   logic [2:0]            alive_ff, alive_in;
   logic                  ovf_ff, ovf_in;

   logic                  accept;
   qshdc_pkg::count_type  depth_c;
   logic                  f_we, l_we, h_we;
   qshdc_pkg::addr_type   f_waddr, l_waddr, h_waddr, h_raddr;
   qshdc_pkg::value_type  h_wdata;
   qshdc_pkg::value_type  f_rdata, l_rdata, h_rdata;
   qshdc_pkg::value_type  best_val;
   qshdc_pkg::addr_type   best_idx;
   qshdc_pkg::max_ctl_type max_ctl;
   qshdc_pkg::count_type  fsum;

   assign accept  = start && !busy;
   assign busy    = state_ff != S_IDLE;
   assign depth_c = CB'(DEPTH);
   assign fsum    = CB'(fhead_ff) + fcount_ff;
   assign f_waddr = fsum[AB-1:0];
   assign l_waddr = lcount_ff[AB-1:0];

   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      fhead_in  = fhead_ff;
      fcount_in = fcount_ff;
      lcount_in = lcount_ff;
      hcount_in = hcount_ff;
      scan_in   = scan_ff;
      alive_in  = alive_ff;
      ovf_in    = ovf_ff;
      f_we      = 1'b0;
      l_we      = 1'b0;
      h_we      = 1'b0;
      h_waddr   = hcount_ff[AB-1:0];
      h_wdata   = req_value;
      h_raddr   = scan_ff[AB-1:0];
      max_ctl   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in   = req_value;
               state_in = S_RSP;
               priority case (req_opcode)
                  qshdc_pkg::OP_INSERT: begin
                     if (alive_ff[0]) begin
                        if (fcount_ff == depth_c) ovf_in = 1'b1;
                        else begin
                           f_we      = 1'b1;
                           fcount_in = fcount_ff + CB'(1);
                        end
                     end
                     if (alive_ff[1]) begin
                        if (lcount_ff == depth_c) ovf_in = 1'b1;
                        else begin
                           l_we      = 1'b1;
                           lcount_in = lcount_ff + CB'(1);
                        end
                     end
                     if (alive_ff[2]) begin
                        if (hcount_ff == depth_c) ovf_in = 1'b1;
                        else begin
                           h_we      = 1'b1;
                           hcount_in = hcount_ff + CB'(1);
                        end
                     end
                  end
                  qshdc_pkg::OP_REMOVE: begin
                     state_in = S_QCHK;
                  end
                  qshdc_pkg::OP_RESTART: begin
                     fhead_in  = '0;
                     fcount_in = '0;
                     lcount_in = '0;
                     hcount_in = '0;
                     alive_in  = 3'b111;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QCHK: begin
            state_in = S_RSP;
            if (alive_ff[0]) begin
               if (fcount_ff == '0 || f_rdata != val_ff) alive_in[0] = 1'b0;
               else begin
                  fhead_in  = fhead_ff + AB'(1);
                  fcount_in = fcount_ff - CB'(1);
               end
            end
            if (alive_ff[1]) begin
               if (lcount_ff == '0 || l_rdata != val_ff) alive_in[1] = 1'b0;
               else lcount_in = lcount_ff - CB'(1);
            end
            if (alive_ff[2]) begin
               if (hcount_ff == '0) alive_in[2] = 1'b0;
               else begin
                  h_raddr       = '0;
                  scan_in       = CB'(1);
                  max_ctl.clear = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            max_ctl.en  = 1'b1;
            max_ctl.idx = AB'(scan_ff - CB'(1));
            if (scan_ff == hcount_ff) state_in = S_HCHK;
            else scan_in = scan_ff + CB'(1);
         end
         S_HCHK: begin
            if (best_val != val_ff) begin
               alive_in[2] = 1'b0;
               state_in    = S_RSP;
            end else begin
               h_raddr  = AB'(hcount_ff - CB'(1));
               state_in = S_HWR;
            end
         end
         S_HWR: begin
            h_we      = 1'b1;
            h_waddr   = best_idx;
            h_wdata   = h_rdata;
            hcount_in = hcount_ff - CB'(1);
            state_in  = S_RSP;
         end
         S_RSP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fhead_ff  <= '0;
         fcount_ff <= '0;
         lcount_ff <= '0;
         hcount_ff <= '0;
         scan_ff   <= '0;
         alive_ff  <= 3'b111;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fhead_ff  <= fhead_in;
         fcount_ff <= fcount_in;
         lcount_ff <= lcount_in;
         hcount_ff <= hcount_in;
         scan_ff   <= scan_in;
         alive_ff  <= alive_in;
         ovf_ff    <= ovf_in;
      end
      val_ff <= val_in;
   end

   qshdc_ram #(.WIDTH(qshdc_pkg::VALUE_BITS), .DEPTH(DEPTH)) u_fifo_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(req_value),
      .raddr(fhead_ff), .rdata(f_rdata)
   );

   qshdc_ram #(.WIDTH(qshdc_pkg::VALUE_BITS), .DEPTH(DEPTH)) u_lifo_ram (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(req_value),
      .raddr(AB'(lcount_ff - CB'(1))), .rdata(l_rdata)
   );

   qshdc_ram #(.WIDTH(qshdc_pkg::VALUE_BITS), .DEPTH(DEPTH)) u_heap_ram (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   qshdc_max_unit u_max (
      .clock(clock), .ctl(max_ctl), .data(h_rdata),
      .best_val(best_val), .best_idx(best_idx)
   );

   assign rsp_valid          = state_ff == S_RSP;
   assign rsp_candidate_mask = alive_ff;
   assign rsp_verdict        = qshdc_pkg::verdict_of(alive_ff);
   assign rsp_overflow       = ovf_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= depth_c && lcount_ff <= depth_c && hcount_ff <= depth_c)
      else $error("model count beyond depth");

   a_alive_revive: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ((alive_ff & ~$past(alive_ff)) != 3'b000))
      |-> $past(accept && req_opcode == qshdc_pkg::OP_RESTART))
      else $error("candidate revived without restart");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(ovf_ff)) else $error("overflow flag cleared");

endmodule

>>> test/queue_stack_heap_discipline_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_stack_heap_discipline_checker_tb
// drives insert, remove, restart and unused-opcode words with random gaps, predicts the
// candidate mask, verdict and overflow flag of each word and checks every
// result word in order against that prediction
// ----------------------------------------------------------------------------
module queue_stack_heap_discipline_checker_tb;

   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0] mask;
      logic [2:0] verdict;
      logic       overflow;
   } status_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] value;
      logic        known;
      status_type  status;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = qshdc_pkg::OP_INSERT;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_candidate_mask;
   logic [2:0]  rsp_verdict;
   logic        rsp_overflow;

   queue_stack_heap_discipline_checker dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] queue_words[$];
   logic [31:0] stack_words[$];
   logic [31:0] prio_words[$];
   logic [2:0]  live_mask;
   logic        drop_seen;

   status_type  status_queue[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   function automatic logic [2:0] mask_verdict(input logic [2:0] m);
      int ones;
      ones = m[0] + m[1] + m[2];
      if (ones == 0) return qshdc_pkg::VERDICT_NONE;
      if (ones > 1) return qshdc_pkg::VERDICT_MULTI;
      if (m[0]) return qshdc_pkg::VERDICT_QUEUE;
      if (m[1]) return qshdc_pkg::VERDICT_STACK;
      return qshdc_pkg::VERDICT_PRIO;
   endfunction

   function automatic status_type predict_status(input logic [1:0] op, input logic [31:0] v);
      int best;
      status_type s;
      if (op == qshdc_pkg::OP_INSERT) begin
         if (live_mask[0]) begin
            if (queue_words.size() >= qshdc_pkg::DEPTH) drop_seen = 1'b1;
            else queue_words.push_back(v);
         end
         if (live_mask[1]) begin
            if (stack_words.size() >= qshdc_pkg::DEPTH) drop_seen = 1'b1;
            else stack_words.push_back(v);
         end
         if (live_mask[2]) begin
            if (prio_words.size() >= qshdc_pkg::DEPTH) drop_seen = 1'b1;
            else prio_words.push_back(v);
         end
      end else if (op == qshdc_pkg::OP_REMOVE) begin
         if (live_mask[0]) begin
            if (queue_words.size() == 0 || queue_words[0] != v) live_mask[0] = 1'b0;
            else void'(queue_words.pop_front());
         end
         if (live_mask[1]) begin
            if (stack_words.size() == 0 || stack_words[$] != v) live_mask[1] = 1'b0;
            else void'(stack_words.pop_back());
         end
         if (live_mask[2]) begin
            if (prio_words.size() == 0) live_mask[2] = 1'b0;
            else begin
               best = 0;
               foreach (prio_words[i]) if (prio_words[i] > prio_words[best]) best = i;
               if (prio_words[best] != v) live_mask[2] = 1'b0;
               else prio_words.delete(best);
            end
         end
      end else if (op == qshdc_pkg::OP_RESTART) begin
         queue_words.delete();
         stack_words.delete();
         prio_words.delete();
         live_mask = 3'b111;
      end
      s.mask = live_mask;
      s.verdict = mask_verdict(live_mask);
      s.overflow = drop_seen;
      return s;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [31:0] v,
                            input logic known, input status_type want);
      status_type s;
      while (!calm && $urandom_range(99) < 35) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      s = predict_status(op, v);
      if (known && s != want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees op %0d value %h: row %h predicted %h",
                     op, v, want, s);
      end
      status_queue.push_back(known ? want : s);
   endtask

   always @(posedge clock) begin
      status_type got;
      status_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid) begin
         got = '{rsp_candidate_mask, rsp_verdict, rsp_overflow};
         if (status_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = status_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected mask %b verdict %0d ovf %b, got %b %0d %b",
                           want.mask, want.verdict, want.overflow,
                           got.mask, got.verdict, got.overflow);
            end
         end
      end
   end

   row_type rows[$];

   function automatic row_type mk(input logic [1:0] op, input logic [31:0] v,
                                  input logic known, input logic [2:0] m);
      row_type r;
      r.op = op;
      r.value = v;
      r.known = known;
      r.status.mask = m;
      r.status.verdict = mask_verdict(m);
      r.status.overflow = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return 32'hFFFFFFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int n;
      logic [31:0] v;
      logic [31:0] pending[$];
      live_mask = 3'b111;
      drop_seen = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(mk(OP_UNUSED, 32'h0, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h0, 1, 3'b000));
      rows.push_back(mk(qshdc_pkg::OP_RESTART, 32'hFFFFFFFF, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h0, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'hFFFFFFFF, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h5, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h5, 1, 3'b010));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'hFFFFFFFF, 1, 3'b010));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h0, 1, 3'b010));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h0, 1, 3'b000));
      rows.push_back(mk(qshdc_pkg::OP_RESTART, 32'h0, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h1, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h9, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h1, 1, 3'b001));
      rows.push_back(mk(qshdc_pkg::OP_RESTART, 32'h0, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h3, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h8, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h2, 1, 3'b111));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h8, 1, 3'b100));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h8, 1, 3'b100));
      rows.push_back(mk(qshdc_pkg::OP_INSERT, 32'h8, 1, 3'b100));
      rows.push_back(mk(qshdc_pkg::OP_REMOVE, 32'h8, 1, 3'b100));
      rows.push_back(mk(OP_UNUSED, 32'hA5A5A5A5, 1, 3'b100));
      rows.push_back(mk(qshdc_pkg::OP_RESTART, 32'h0, 1, 3'b111));
      foreach (rows[i]) send_word(rows[i].op, rows[i].value, rows[i].known, rows[i].status);

      // fill past depth to hit the overflow path, all models alive
      calm = 1'b1;
      for (int i = 0; i < qshdc_pkg::DEPTH + 2; i++)
         send_word(qshdc_pkg::OP_INSERT, $urandom, 0, '0);
      calm = 1'b0;
      send_word(qshdc_pkg::OP_RESTART, 32'h0, 0, '0);

      n = 0;
      while (n < 700) begin
         calm = (n >= 300 && n < 400);
         pending.delete();
         repeat ($urandom_range(1, 8)) begin
            v = rand_value();
            pending.push_back(v);
            send_word(qshdc_pkg::OP_INSERT, v, 0, '0);
            n++;
         end
         // well-formed removals in one discipline, sometimes broken
         case ($urandom_range(3))
            0: pending.sort();
            1: pending.rsort();
            default: ;
         endcase
         if ($urandom_range(1)) pending.reverse();
         while (pending.size() > 0) begin
            v = pending.pop_front();
            if ($urandom_range(9) == 0) v = $urandom;
            send_word(qshdc_pkg::OP_REMOVE, v, 0, '0);
            n++;
         end
         case ($urandom_range(9))
            0: send_word(qshdc_pkg::OP_REMOVE, rand_value(), 0, '0);
            1: send_word(OP_UNUSED, $urandom, 0, '0);
            default: send_word(qshdc_pkg::OP_RESTART, $urandom, 0, '0);
         endcase
         n++;
      end
      start <= 1'b0;

      while (status_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
